>>> src/assert_macros.svh
// Assertion macros used by the ring bookkeeping RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/vrr_pkg.sv
// Types and constants of the variable-length record ring bookkeeping engine.
package vrr_pkg;

  localparam int MSG_W     = 12;
  localparam int OFF_W     = 12;
  localparam int LEN_W     = 12;
  localparam int SEQ_W     = 16;
  localparam int DROP_W    = 11;
  localparam int HDR_BYTES = 4;

  localparam logic [15:0] WRAP_MARK = 16'hFFFF;

  // Request kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [MSG_W-1:0] msg_length;
  } req_item_t;

  typedef struct packed {
    logic              valid_res;
    logic [OFF_W-1:0]  record_offset;
    logic [LEN_W-1:0]  record_length;
    logic [SEQ_W-1:0]  record_sequence;
    logic [DROP_W-1:0] dropped;
    logic              wrapped;
  } rsp_item_t;

  // Record header as kept in the header memory
  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] len;
  } hdr_t;

  // Header memory command
  typedef struct packed {
    logic rd;
    logic wr;
  } hdr_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_EVAL,
    ST_ENQ_WAIT,
    ST_DEQ_RD,
    ST_DEQ_W1,
    ST_DEQ_W2
  } st_t;

endpackage

>>> src/vrr_channels.sv
// Request and response channel interfaces of the record ring engine.
interface vrr_req_if
  import vrr_pkg::*;
  ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vrr_rsp_if
  import vrr_pkg::*;
  ();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/vrr_hdr_mem.sv
// Record header memory: one write and one read per cycle, registered read data.
module vrr_hdr_mem
  import vrr_pkg::*;
#(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  hdr_cmd_t          cmd,
  input  logic [ADDR_W-1:0] addr,
  input  hdr_t              wdata,
  output hdr_t              rdata
);

  localparam int IDX_W = $clog2(DEPTH);

  hdr_t             mem [DEPTH];
  hdr_t             rdata_q;
  logic             oob;
  logic             in_range;
  logic [IDX_W-1:0] idx;

  assign in_range = addr < ADDR_W'(DEPTH);
  assign idx      = IDX_W'(addr);

  // Write only inside the ring
  always_ff @(posedge clk) begin
    if (cmd.wr && in_range) begin
      mem[idx] <= wdata;
    end
  end

  // Read and hold until the next read; beyond the ring reads as zero
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      oob <= !in_range;
      if (in_range) begin
        rdata_q <= mem[idx];
      end
    end
  end

  assign rdata = oob ? '0 : rdata_q;

endmodule

>>> src/vrr_ctrl.sv
// Pointer, count and sequence control with the drop walk and the result register.
`include "assert_macros.svh"

module vrr_ctrl
  import vrr_pkg::*;
#(
  parameter int BUF_BYTES = 4096,
  parameter int MAX_MSG   = 2048,
  parameter int ADDR_W    = 13
) (
  input  logic              clk,
  input  logic              rst,
  vrr_req_if.sink           req,
  vrr_rsp_if.source         rsp,
  output hdr_cmd_t          mem_cmd,
  output logic [ADDR_W-1:0] mem_addr,
  output hdr_t              mem_wdata,
  input  hdr_t              mem_rdata
);

  localparam int END_OFF = BUF_BYTES - 2;
  localparam int NW      = $clog2(MAX_MSG + HDR_BYTES + 1);
  localparam int CW      = $clog2(BUF_BYTES / HDR_BYTES + 2);
  localparam int XW0     = (ADDR_W > NW) ? ADDR_W : NW;
  localparam int XW      = ((XW0 > MSG_W) ? XW0 : MSG_W) + 1;
  localparam int DW      = ((ADDR_W > 16) ? ADDR_W : 16) + 1;

  st_t               state, state_next;
  logic [ADDR_W-1:0] wr, wr_next;
  logic [ADDR_W-1:0] rd, rd_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [SEQ_W-1:0]  seq, seq_next;
  logic [NW-1:0]     need, need_next;
  logic [DROP_W-1:0] drops, drops_next;
  logic              wrap, wrap_next;
  logic              rsp_valid, rsp_valid_next;
  rsp_item_t         rsp_data, rsp_data_next;

  logic [XW-1:0]     msg_x, sat_x, wr_x, rd_x, need_x, wr_end;
  logic [NW-1:0]     need_in;
  logic [DW-1:0]     walk_sum;
  logic [ADDR_W-1:0] deq_rd;
  logic              slot_free, too_big, fit_end, gap_ok, is_mark;

  // Saturate the message length and add the header
  assign msg_x   = XW'(req.data.msg_length);
  assign sat_x   = (msg_x > XW'(MAX_MSG)) ? XW'(MAX_MSG) : msg_x;
  assign need_in = NW'(sat_x + XW'(HDR_BYTES));

  // Fit checks against the usable end and the gap to the oldest record
  assign wr_x    = XW'(wr);
  assign rd_x    = XW'(rd);
  assign need_x  = XW'(need);
  assign wr_end  = wr_x + need_x;
  assign too_big = need_x > XW'(END_OFF);
  assign fit_end = wr_end <= XW'(END_OFF);
  assign gap_ok  = rd_x >= wr_end;

  // Advance past the header just read; clamp for a dequeue
  assign is_mark  = mem_rdata.len == WRAP_MARK;
  assign walk_sum = DW'(rd) + DW'(mem_rdata.len);
  assign deq_rd   = (walk_sum > DW'(BUF_BYTES)) ? ADDR_W'(BUF_BYTES) : ADDR_W'(walk_sum);

  assign slot_free = !rsp_valid || rsp.ready;
  assign req.ready = state == ST_IDLE;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr        <= '0;
      rd        <= '0;
      cnt       <= '0;
      seq       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wr        <= wr_next;
      rd        <= rd_next;
      cnt       <= cnt_next;
      seq       <= seq_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    need     <= need_next;
    drops    <= drops_next;
    wrap     <= wrap_next;
    rsp_data <= rsp_data_next;
  end

  always_comb begin
    state_next     = state;
    wr_next        = wr;
    rd_next        = rd;
    cnt_next       = cnt;
    seq_next       = seq;
    need_next      = need;
    drops_next     = drops;
    wrap_next      = wrap;
    rsp_valid_next = rsp_valid && !rsp.ready;
    rsp_data_next  = rsp_data;
    mem_cmd        = '0;
    mem_addr       = wr;
    mem_wdata      = '{seq: 16'h0000, len: WRAP_MARK};

    unique case (state)
      ST_IDLE: begin
        // Latch the request on transfer
        if (req.valid) begin
          need_next  = need_in;
          drops_next = '0;
          wrap_next  = 1'b0;
          state_next = (req.data.kind == KIND_DEQ) ? ST_DEQ_RD : ST_ENQ_EVAL;
        end
      end

      ST_ENQ_EVAL: begin
        if (too_big) begin
          // Refuse a record that can never fit
          if (slot_free) begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = '0;
            state_next     = ST_IDLE;
          end
        end else if (cnt == '0 && !fit_end) begin
          // Empty ring, no room to the end: mark and restart at zero
          mem_cmd.wr = 1'b1;
          wr_next    = '0;
          rd_next    = '0;
          wrap_next  = 1'b1;
        end else if (cnt != '0 && rd >= wr && !gap_ok) begin
          // Gap too small: fetch the oldest header to drop it
          mem_cmd.rd = 1'b1;
          mem_addr   = rd;
          state_next = ST_ENQ_WAIT;
        end else if (cnt != '0 && rd < wr && !fit_end) begin
          // Reader behind: mark and restart writing at zero
          mem_cmd.wr = 1'b1;
          wr_next    = '0;
          wrap_next  = 1'b1;
        end else if (slot_free) begin
          // Place the record
          mem_cmd.wr     = 1'b1;
          mem_wdata      = '{seq: seq, len: 16'(need)};
          rsp_valid_next = 1'b1;
          rsp_data_next  = '{valid_res:       1'b1,
                             record_offset:   OFF_W'(wr),
                             record_length:   LEN_W'(need),
                             record_sequence: seq,
                             dropped:         drops,
                             wrapped:         wrap};
          if (cnt == '0) begin
            rd_next = wr;
          end
          cnt_next   = cnt + 1'b1;
          wr_next    = ADDR_W'(wr_end);
          seq_next   = seq + 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_ENQ_WAIT: begin
        // Follow a wrap marker or drop the oldest record
        if (is_mark) begin
          rd_next = '0;
        end else begin
          rd_next  = ADDR_W'(walk_sum);
          cnt_next = cnt - 1'b1;
          if (drops != '1) begin
            drops_next = drops + 1'b1;
          end
        end
        state_next = ST_ENQ_EVAL;
      end

      ST_DEQ_RD: begin
        if (cnt == '0) begin
          // Empty queue
          if (slot_free) begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = '0;
            state_next     = ST_IDLE;
          end
        end else begin
          mem_cmd.rd = 1'b1;
          mem_addr   = rd;
          state_next = ST_DEQ_W1;
        end
      end

      ST_DEQ_W1, ST_DEQ_W2: begin
        if (state == ST_DEQ_W1 && is_mark) begin
          // Wrap marker at the reader: restart at zero and read again
          rd_next    = '0;
          mem_cmd.rd = 1'b1;
          mem_addr   = '0;
          state_next = ST_DEQ_W2;
        end else if (slot_free) begin
          rsp_valid_next = 1'b1;
          rsp_data_next  = '{valid_res:       1'b1,
                             record_offset:   OFF_W'(rd),
                             record_length:   LEN_W'(mem_rdata.len),
                             record_sequence: mem_rdata.seq,
                             dropped:         '0,
                             wrapped:         1'b0};
          rd_next        = deq_rd;
          cnt_next       = cnt - 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_mem_excl, clk, rst, !(mem_cmd.rd && mem_cmd.wr), "header memory read and write together")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready, "second request taken while busy")
  `ASSERT_NEXT(a_empty_deq, clk, rst, state == ST_DEQ_RD && cnt == '0 && slot_free, rsp_valid && !rsp_data.valid_res, "empty dequeue did not report empty")
  `ASSERT_NEXT(a_drop_count, clk, rst, state == ST_ENQ_WAIT && !is_mark, cnt == CW'($past(cnt) - 1'b1), "drop did not lower the record count")

endmodule

>>> src/variable_record_ring_drop_oldest_unit.sv
// Top level of the variable-length record ring bookkeeping engine.
// Enqueue: ST_ENQ_EVAL places the record and registers the result; each drop and each wrap marker
// followed at the reader adds a pass through ST_ENQ_WAIT, each marker written a further pass
// through ST_ENQ_EVAL. Dequeue: ST_DEQ_RD reads, then ST_DEQ_W1 answers, or ST_DEQ_W2
// after a wrap marker at the reader; refusals and empty dequeues answer in ST_ENQ_EVAL, ST_DEQ_RD.
// Results wait out rsp back-pressure; one request in flight, req.ready returns with the result.
// Reset (rst, synchronous) clears pointers, count and sequence; the header memory is not cleared.
module variable_record_ring_drop_oldest_unit
  import vrr_pkg::*;
#(
  parameter int BUF_BYTES = 4096,
  parameter int MAX_MSG   = 2048
) (
  input  logic      clk,
  input  logic      rst,
  vrr_req_if.sink   req,
  vrr_rsp_if.source rsp
);

  localparam int ADDR_W = $clog2(BUF_BYTES + 1);

  hdr_cmd_t          mem_cmd;
  logic [ADDR_W-1:0] mem_addr;
  hdr_t              mem_wdata;
  hdr_t              mem_rdata;

  vrr_ctrl #(
    .BUF_BYTES (BUF_BYTES),
    .MAX_MSG   (MAX_MSG),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  vrr_hdr_mem #(
    .DEPTH  (BUF_BYTES),
    .ADDR_W (ADDR_W)
  ) u_hdr_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

>>> test/variable_record_ring_drop_oldest_unit_test.sv
// Testbench for the variable-length record ring engine: random traffic checked against a predictor.
`timescale 1ns / 100ps

module variable_record_ring_drop_oldest_unit_test
  import vrr_pkg::*;
  ();

  localparam int unsigned BUF_BYTES  = 4096;
  localparam int unsigned MAX_MSG    = 2048;
  localparam int unsigned RING_END   = BUF_BYTES - 2;
  localparam int unsigned ITEMS      = 900;
  localparam int unsigned LIMIT      = 300000;
  localparam int unsigned DRAIN      = 50;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned HOLD_AFTER = 150;

  // Predicts the ring bookkeeping and checks results in transfer order
  class ring_ledger #(int unsigned RING_BYTES = 4096, int unsigned MSG_MAX = 2048);
    localparam int unsigned END_OFF  = RING_BYTES - 2;
    localparam int unsigned WALK_CAP = 2 * RING_BYTES + 8;

    int unsigned wr;
    int unsigned rd;
    int unsigned held;
    int unsigned next_seq;
    bit [31:0]   hdrs [RING_BYTES];
    rsp_item_t   records_due [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      wr = 0;
      rd = 0;
      held = 0;
      next_seq = 0;
      mismatches = 0;
      checked = 0;
      foreach (hdrs[i]) hdrs[i] = '0;
    endfunction

    function bit [31:0] hdr_at(int unsigned off);
      return (off < RING_BYTES) ? hdrs[off] : 32'd0;
    endfunction

    // Keep the sequence half of the old header, overwrite the length half
    function void put_marker(int unsigned off);
      if (off < RING_BYTES) hdrs[off] = {hdrs[off][31:16], WRAP_MARK};
    endfunction

    function bit fits(int unsigned off, int unsigned need);
      return off <= END_OFF && END_OFF - off >= need;
    endfunction

    function void note_request(req_item_t rq);
      rsp_item_t   r;
      int unsigned msg;
      int unsigned need;
      int unsigned drops;
      int unsigned steps;
      bit [31:0]   h;
      bit          wrap;
      r = '0;
      if (rq.kind == KIND_ENQ) begin
        msg = 32'(rq.msg_length);
        if (msg > MSG_MAX) msg = MSG_MAX;
        need = msg + HDR_BYTES;
        // Refuse a record that can never fit
        if (need <= END_OFF) begin
          drops = 0;
          wrap = 1'b0;
          steps = 0;
          // Walk until the record has room, wrapping and dropping oldest
          forever begin
            steps++;
            if (steps > WALK_CAP) begin
              held = 0;
              rd = 0;
              wr = 0;
              break;
            end
            if (held == 0) begin
              rd = wr;
              if (fits(wr, need)) break;
              put_marker(wr);
              wr = 0;
              rd = 0;
              wrap = 1'b1;
            end else if (rd >= wr) begin
              if (rd - wr >= need) break;
              h = hdr_at(rd);
              if (h[15:0] == WRAP_MARK) begin
                rd = 0;
              end else begin
                rd += 32'(h[15:0]);
                held--;
                if (drops < 2047) drops++;
              end
            end else begin
              if (fits(wr, need)) break;
              put_marker(wr);
              wr = 0;
              wrap = 1'b1;
            end
          end
          if (wr < RING_BYTES) hdrs[wr] = {next_seq[15:0], need[15:0]};
          r.valid_res       = 1'b1;
          r.record_offset   = wr[OFF_W-1:0];
          r.record_length   = need[LEN_W-1:0];
          r.record_sequence = next_seq[SEQ_W-1:0];
          r.dropped         = drops[DROP_W-1:0];
          r.wrapped         = wrap;
          held++;
          wr += need;
          next_seq = (next_seq + 1) & 32'hFFFF;
        end
      end else if (held != 0) begin
        // Follow a wrap marker at the reader, then take the oldest record
        h = hdr_at(rd);
        if (h[15:0] == WRAP_MARK) rd = 0;
        h = hdr_at(rd);
        r.valid_res       = 1'b1;
        r.record_offset   = rd[OFF_W-1:0];
        r.record_length   = h[LEN_W-1:0];
        r.record_sequence = h[31:16];
        rd += 32'(h[15:0]);
        if (rd > RING_BYTES) rd = RING_BYTES;
        held--;
      end
      records_due.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0d, actual %0d", field, want, got);
      end
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t want;
      checked++;
      if (records_due.size() == 0) begin
        mismatches++;
        $error("result transfer with no request outstanding");
        return;
      end
      want = records_due.pop_front();
      compare_field("valid_res", 32'(want.valid_res), 32'(got.valid_res));
      compare_field("record_offset", 32'(want.record_offset), 32'(got.record_offset));
      compare_field("record_length", 32'(want.record_length), 32'(got.record_length));
      compare_field("record_sequence", 32'(want.record_sequence),
                    32'(got.record_sequence));
      compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
      compare_field("wrapped", 32'(want.wrapped), 32'(got.wrapped));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  vrr_req_if req_ch ();
  vrr_rsp_if rsp_ch ();

  ring_ledger #(BUF_BYTES, MAX_MSG) board;

  int unsigned sent;
  int unsigned burst_left;
  int unsigned cycles;

  variable_record_ring_drop_oldest_unit #(
    .BUF_BYTES(BUF_BYTES),
    .MAX_MSG  (MAX_MSG)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) board.check_result(rsp_ch.data);
  end

  // Offer one request, hold it until the transfer, then idle at burst ends
  task automatic push_request(input logic k, input logic [MSG_W-1:0] len);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data  <= {k, len};
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_request(req_ch.data);
    sent++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6)) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
    end
  endtask

  // Enqueue pieces until the write pointer lands exactly on target
  task automatic fill_ring_to(input int unsigned target);
    int unsigned gap;
    gap = (target >= board.wr) ? target - board.wr : 0;
    while (gap >= HDR_BYTES) begin
      if (gap - HDR_BYTES <= MAX_MSG) push_request(KIND_ENQ, MSG_W'(gap - HDR_BYTES));
      else push_request(KIND_ENQ, MSG_W'(1024));
      gap = (target >= board.wr) ? target - board.wr : 0;
    end
  endtask

  function automatic logic [MSG_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return MSG_W'($urandom_range(0, 16));
      4, 5:       return MSG_W'($urandom_range(17, 400));
      6, 7:       return MSG_W'($urandom_range(401, MAX_MSG));
      8:          return MSG_W'($urandom_range(MAX_MSG + 1, 4095));
      default:    return MSG_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Receiver: stall on shifting patterns, with one long hold-off
  initial begin : receiver
    int unsigned mode;
    int unsigned tick;
    bit          held_off;
    logic        rdy;
    tick = 0;
    held_off = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk);
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (tick % 5) >= 2;
          default: rdy = (tick % 7) != 0;
        endcase
        rsp_ch.ready <= rdy;
        tick++;
      end
      if (!held_off && board.checked >= HOLD_AFTER) begin
        held_off = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          rsp_ch.ready <= 1'b0;
        end
      end
    end
  end

  // Sender: reset, directed cases, random traffic, then drain
  initial begin : sender
    int unsigned n;
    board = new();
    sent = 0;
    cycles = 0;
    burst_left = 8;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty dequeue, shortest and longest records, saturated lengths
    push_request(KIND_DEQ, 12'hFFF);
    push_request(KIND_ENQ, MSG_W'(0));
    push_request(KIND_ENQ, 12'hFFF);
    push_request(KIND_ENQ, MSG_W'(MAX_MSG));
    push_request(KIND_ENQ, MSG_W'(MAX_MSG + 1));
    // Dequeue until empty, then once more
    while (board.held != 0) push_request(KIND_DEQ, MSG_W'(0));
    push_request(KIND_DEQ, 12'h555);
    // Fill exactly to the usable end, then force a wrap
    fill_ring_to(RING_END);
    push_request(KIND_ENQ, MSG_W'(100));
    // Fill exactly up to the reader, then drop from a full ring
    fill_ring_to(board.rd);
    push_request(KIND_ENQ, MSG_W'(0));
    push_request(KIND_DEQ, 12'hAAA);
    push_request(KIND_DEQ, MSG_W'(0));

    // Random traffic: mostly enqueues that keep the ring wrapping and dropping
    while (sent < ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          repeat ($urandom_range(20, 60)) push_request(KIND_ENQ, MSG_W'($urandom_range(0, 12)));
        end
        3, 4: begin
          n = (board.held + 2 > 40) ? 40 : board.held + 2;
          repeat (n) push_request(KIND_DEQ, MSG_W'($urandom_range(0, 4095)));
        end
        5, 6: begin
          push_request(KIND_ENQ, MSG_W'($urandom_range(1500, MAX_MSG)));
        end
        default: begin
          push_request(($urandom_range(0, 99) < 65) ? KIND_ENQ : KIND_DEQ, pick_length());
        end
      endcase
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Wait out every outstanding result, then a short quiet tail
    while (board.records_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (board.mismatches == 0 && board.records_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
